// ===== rtl/sine_tone_segment_generator_defines.svh =====
// assertion macros for the sine tone segment generator
`ifndef SINE_TONE_SEGMENT_GENERATOR_DEFINES_SVH
`define SINE_TONE_SEGMENT_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stsg_pkg.sv =====
package stsg_pkg;

    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_SAMPLES_PER_MS  = 22;

    localparam int AMP_W   = 15;
    localparam int FREQ_W  = 16;
    localparam int DUR_W   = 16;
    localparam int SINE_W  = 16;
    localparam int LEFT_W  = 21;
    localparam int PROD_W  = 2 * AMP_W;

    localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(16000);
    localparam logic [SINE_W-1:0] SINE_FULL  = SINE_W'(32767);
    localparam logic [LEFT_W-1:0] LEFT_MAX   = '1;

    localparam int TONE_RATE      = 22000;
    localparam int TONE_HALF_RATE = TONE_RATE / 2;

    // rate = 16 * RATE_ODD; the odd part is divided by reciprocal multiply
    localparam int RATE_SHIFT = 4;
    localparam int RATE_ODD   = TONE_RATE / (1 << RATE_SHIFT);
    localparam int Y_W        = 31;
    localparam int DIV_Z_W    = Y_W - RATE_SHIFT;
    localparam int DIV_SHIFT  = DIV_Z_W + 11;
    localparam logic [63:0] DIV_MUL =
        ((64'd1 << DIV_SHIFT) + 64'(RATE_ODD) - 64'd1) / 64'(RATE_ODD);
    localparam int DIV_M_W    = 28;
    localparam int DIV_P_W    = DIV_Z_W + DIV_M_W;
    localparam int QUOT_W     = 16;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    // series term divisors as reciprocals, exact for dividends below 2^32
    localparam int TAYLOR_SHIFT = 40;
    localparam logic [63:0] TAYLOR_RCP_6   = ((64'd1 << TAYLOR_SHIFT) + 64'd5) / 64'd6;
    localparam logic [63:0] TAYLOR_RCP_20  = ((64'd1 << TAYLOR_SHIFT) + 64'd19) / 64'd20;
    localparam logic [63:0] TAYLOR_RCP_42  = ((64'd1 << TAYLOR_SHIFT) + 64'd41) / 64'd42;
    localparam logic [63:0] TAYLOR_RCP_72  = ((64'd1 << TAYLOR_SHIFT) + 64'd71) / 64'd72;
    localparam logic [63:0] TAYLOR_RCP_110 = ((64'd1 << TAYLOR_SHIFT) + 64'd109) / 64'd110;
    localparam logic [63:0] TAYLOR_RCP_156 = ((64'd1 << TAYLOR_SHIFT) + 64'd155) / 64'd156;
    localparam logic [63:0] TAYLOR_RCP_210 = ((64'd1 << TAYLOR_SHIFT) + 64'd209) / 64'd210;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [FREQ_W-1:0] freq_hz;
        logic [DUR_W-1:0]  duration_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [SINE_W-1:0] sample;
        logic                     active;
        logic                     last;
    } t_out_item;

    function automatic logic [63:0] taylor_rcp(input int n);
        logic [63:0] d;
        case (n)
            0:       d = TAYLOR_RCP_6;
            1:       d = TAYLOR_RCP_20;
            2:       d = TAYLOR_RCP_42;
            3:       d = TAYLOR_RCP_72;
            4:       d = TAYLOR_RCP_110;
            5:       d = TAYLOR_RCP_156;
            default: d = TAYLOR_RCP_210;
        endcase
        return d;
    endfunction

    // quarter-wave entry k: round(32767 * sin(k * pi / 2^(tb+1))), q2.30 series
    function automatic logic [SINE_W-1:0] rom_entry(input logic [31:0] k, input int tb);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  v;
        logic [127:0] wide;
        x    = (64'(HALF_PI_Q30) * 64'(k)) >> tb;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 0; n < 7; n++) begin
            term = (term * x2) >> 30;
            wide = 128'(term) * 128'(taylor_rcp(n));
            term = wide[TAYLOR_SHIFT +: 64];
            if ((n % 2) == 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'(SINE_FULL) + (64'd1 << 29)) >> 30;
        if (v > 64'(SINE_FULL)) begin
            v = 64'(SINE_FULL);
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ===== rtl/sine_tone_segment_generator.sv =====
// a tick item passes the stage registers s1 to s7 in order before its result is offered at the output
// throughput: one item per cycle while the output is not stalled; ready is a chain over the seven stage valid bits
// the step for a load is built over three stages (constant multiplies, reciprocal divide)
// reset (synchronous, active low) clears phase, step, remaining count and stage valids
// and sets amplitude to 16000; the sine table is constant and needs no fill
`include "sine_tone_segment_generator_defines.svh"

module sine_tone_segment_generator import stsg_pkg::*; #(
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int SAMPLES_PER_MS  = DEF_SAMPLES_PER_MS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [AMP_W-1:0] i_cfg_amplitude
);

    localparam int TB        = SINE_TABLE_BITS;
    localparam int PB        = PHASE_BITS;
    localparam int ROM_DEPTH = 1 << TB;
    localparam int ROM_BITS  = ROM_DEPTH * SINE_W;
    localparam logic [63:0] TWO_PB = 64'd1 << PB;
    localparam logic [63:0] STEP_Q = TWO_PB / 64'(TONE_RATE);
    localparam logic [63:0] STEP_R = TWO_PB % 64'(TONE_RATE);
    localparam int SPM_W = $clog2(SAMPLES_PER_MS + 1);
    localparam int CNT_W = DUR_W + SPM_W;
    localparam int SAT_W = CNT_W + LEFT_W;

    function automatic logic [ROM_BITS-1:0] build_rom();
        logic [ROM_BITS-1:0] rom;
        rom = '0;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            rom[k*SINE_W +: SINE_W] = rom_entry(32'(k), TB);
        end
        return rom;
    endfunction

    localparam logic [ROM_BITS-1:0] SINE_ROM = build_rom();

    logic take_s1, take_s2, take_s3, take_s4, take_s5, take_s6, take_s7;

    logic             r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic [AMP_W-1:0] r_amplitude;

    logic [PB-1:0]     r_phase_acc;
    logic [PB-1:0]     r_phase_step;
    logic [LEFT_W-1:0] r_left;

    t_in_item          r1_item;

    logic              r2_req;
    logic [PB-1:0]     r2_fq;
    logic [Y_W-1:0]    r2_y;
    logic [LEFT_W-1:0] r2_cnt;

    logic              r3_req;
    logic [PB-1:0]     r3_fq;
    logic [QUOT_W-1:0] r3_q;
    logic [LEFT_W-1:0] r3_cnt;

    logic          r4_act;
    logic          r4_last;
    logic [TB+1:0] r4_phase;

    logic              r5_act;
    logic              r5_last;
    logic              r5_neg;
    logic              r5_full;
    logic [SINE_W-1:0] r5_rom;

    logic              r6_last;
    logic              r6_act;
    logic              r6_neg;
    logic [PROD_W-1:0] r6_prod;

    t_out_item r7_item;

    logic [CNT_W-1:0]   n_cnt;
    logic [LEFT_W-1:0]  n_cnt_sat;
    logic [DIV_P_W-1:0] n_div_prod;
    logic [PB-1:0]      n_phase;
    logic [PB-1:0]      n_step;
    logic [TB-1:0]      n_idx;
    logic [TB-1:0]      n_addr;
    logic [SINE_W-1:0]  n_mag;
    logic [PROD_W:0]    n_quot_sum;
    logic [AMP_W-1:0]   n_val;

    assign take_s7 = !r_v7 || i_out_ready;
    assign take_s6 = !r_v6 || take_s7;
    assign take_s5 = !r_v5 || take_s6;
    assign take_s4 = !r_v4 || take_s5;
    assign take_s3 = !r_v3 || take_s4;
    assign take_s2 = !r_v2 || take_s3;
    assign take_s1 = !r_v1 || take_s2;

    assign o_in_ready  = take_s1;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_v7;
    assign o_out_item  = r7_item;

    always_comb begin
        n_cnt = CNT_W'(r1_item.duration_ms) * CNT_W'(SAMPLES_PER_MS);
        if (SAT_W'(n_cnt) > SAT_W'(LEFT_MAX)) begin
            n_cnt_sat = LEFT_MAX;
        end else begin
            n_cnt_sat = LEFT_W'(n_cnt);
        end
        n_div_prod = DIV_P_W'(r2_y[Y_W-1:RATE_SHIFT]) * DIV_P_W'(DIV_MUL[DIV_M_W-1:0]);
        n_step     = r3_fq + PB'(r3_q);
        n_phase    = r_phase_acc + r_phase_step;
        n_idx      = r4_phase[TB-1:0];
        n_addr     = r4_phase[TB] ? TB'(~n_idx + 1'b1) : n_idx;
        n_mag      = r5_full ? SINE_FULL : r5_rom;
        // exact floor division by 2^15 - 1
        n_quot_sum = (PROD_W+1)'(r6_prod) + (PROD_W+1)'(r6_prod >> AMP_W) + (PROD_W+1)'(1);
        n_val      = n_quot_sum[AMP_W +: AMP_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_v5         <= 1'b0;
            r_v6         <= 1'b0;
            r_v7         <= 1'b0;
            r_amplitude  <= AMP_RESET;
            r_phase_acc  <= '0;
            r_phase_step <= '0;
            r_left       <= '0;
        end else begin
            if (take_s1) begin
                r_v1 <= i_in_valid;
            end
            if (take_s2) begin
                r_v2 <= r_v1;
            end
            if (take_s3) begin
                r_v3 <= r_v2;
            end
            if (take_s4) begin
                r_v4 <= r_v3 && (r3_req == REQ_TICK);
            end
            if (take_s5) begin
                r_v5 <= r_v4;
            end
            if (take_s6) begin
                r_v6 <= r_v5;
            end
            if (take_s7) begin
                r_v7 <= r_v6;
            end
            if (i_cfg_valid) begin
                r_amplitude <= i_cfg_amplitude;
            end
            if (r_v3 && take_s4) begin
                if (r3_req == REQ_LOAD) begin
                    r_phase_acc  <= '0;
                    r_phase_step <= n_step;
                    r_left       <= r3_cnt;
                end else if (r_left != '0) begin
                    r_phase_acc <= n_phase;
                    r_left      <= r_left - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_s1) begin
            r1_item <= i_in_item;
        end
        if (take_s2) begin
            r2_req <= r1_item.req_type;
            r2_fq  <= PB'(r1_item.freq_hz) * PB'(STEP_Q);
            r2_y   <= Y_W'(r1_item.freq_hz) * Y_W'(STEP_R) + Y_W'(TONE_HALF_RATE);
            r2_cnt <= n_cnt_sat;
        end
        if (take_s3) begin
            r3_req <= r2_req;
            r3_fq  <= r2_fq;
            r3_q   <= n_div_prod[DIV_SHIFT +: QUOT_W];
            r3_cnt <= r2_cnt;
        end
        if (take_s4) begin
            r4_act   <= r_left != '0;
            r4_last  <= r_left == LEFT_W'(1);
            r4_phase <= n_phase[PB-1 -: TB+2];
        end
        if (take_s5) begin
            r5_act  <= r4_act;
            r5_last <= r4_last;
            r5_neg  <= r4_phase[TB+1];
            r5_full <= r4_phase[TB] && (n_idx == '0);
            r5_rom  <= SINE_ROM[{n_addr, 4'b0000} +: SINE_W];
        end
        if (take_s6) begin
            r6_act  <= r5_act;
            r6_last <= r5_last && r5_act;
            r6_neg  <= r5_neg && r5_act;
            r6_prod <= r5_act ? PROD_W'(r_amplitude) * PROD_W'(n_mag[AMP_W-1:0]) : '0;
        end
        if (take_s7) begin
            r7_item.sample <= r6_neg ? -$signed(SINE_W'(n_val)) : $signed(SINE_W'(n_val));
            r7_item.active <= r6_act;
            r7_item.last   <= r6_last;
        end
    end

    `STSG_ASSERT_NOW(a_idle_result_zero, o_out_valid && !o_out_item.active, (o_out_item.sample == '0) && !o_out_item.last, "idle result carries data")
    `STSG_ASSERT_NOW(a_ready_when_out_free, !r_v7, o_in_ready, "input stalled with free output stage")
    `STSG_ASSERT_NEXT(a_tick_moves_phase, r_v3 && take_s4 && (r3_req == REQ_TICK) && (r_left != '0), r_phase_acc == $past(r_phase_acc + r_phase_step), "phase did not advance on tick")
    `STSG_ASSERT_NEXT(a_load_arms_count, r_v3 && take_s4 && (r3_req == REQ_LOAD), (r_left == $past(r3_cnt)) && (r_phase_acc == '0), "load did not arm segment")

endmodule
